// File: design/mrgt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mrgt_pkg;

  // Default table depth and configuration reset value.
  localparam int unsigned MAX_GAPS_DEFAULT = 64;
  localparam logic [31:0] TEMP_SIZE_RESET  = 32'hFFFF_FFFF;

  // Operation codes of an input item.
  localparam logic [1:0] OP_START   = 2'd0;
  localparam logic [1:0] OP_SEGMENT = 2'd1;
  localparam logic [1:0] OP_FINAL   = 2'd2;

  // Outcome codes of a result item.
  localparam logic [2:0] OUT_IGNORED = 3'd0;
  localparam logic [2:0] OUT_REMOVED = 3'd1;
  localparam logic [2:0] OUT_TRIMMED = 3'd2;
  localparam logic [2:0] OUT_SPLIT   = 3'd3;
  localparam logic [2:0] OUT_FULL    = 3'd4;
  localparam logic [2:0] OUT_STARTED = 3'd5;
  localparam logic [2:0] OUT_RESIZED = 3'd6;
  localparam logic [2:0] OUT_NOGAP   = 3'd7;

  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] seg_start;
    logic [31:0] seg_end;
    logic [31:0] final_size;
  } in_t;

  typedef struct packed {
    logic [2:0] outcome;
    logic [6:0] gap_total;
    logic       all_received;
  } out_t;

endpackage

`default_nettype wire

// File: design/missing_range_gap_tracker_core.sv
`timescale 1ns / 1ps
`default_nettype none
// Sequence: start, reversed, unused-op and empty-table final-size items go straight to the
// finish step; other final-size items pass a resize step first, and segment items a scan
// at one entry per cycle, then, for a removal or a split, a shift of the table tail at one
// entry per cycle; a stalled result register holds the finish step until it is free.
// Flow: one item at a time; the next item can be accepted once the result item is valid.
// Reset: asynchronous, active low; gap count to zero, temp_size to all ones, memory kept.

module missing_range_gap_tracker_core #(
  parameter int unsigned MAX_GAPS = mrgt_pkg::MAX_GAPS_DEFAULT
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output      logic           in_ready_o,
  input  wire mrgt_pkg::in_t  in_data_i,
  output      logic           out_valid_o,
  input  wire logic           out_ready_i,
  output      mrgt_pkg::out_t out_data_o,
  input  wire logic           cfg_we_i,
  input  wire logic [31:0]    cfg_wdata_i
);

  import mrgt_pkg::*;

  localparam int unsigned AW = $clog2(MAX_GAPS);
  localparam int unsigned CW = $clog2(MAX_GAPS + 1);

  // Sequencer states.
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_ACT  = 3'd2;
  localparam logic [2:0] S_SHF  = 3'd3;
  localparam logic [2:0] S_SPL  = 3'd4;
  localparam logic [2:0] S_RSZ  = 3'd5;
  localparam logic [2:0] S_DONE = 3'd6;

  logic [2:0]    st_q, st_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [31:0]   temp_q;

  // Latched fields of the item being worked on.
  logic [31:0]   s_q, s_d, e_q, e_d, fs_q, fs_d;

  // Scan pointer, compare-stage valid and index.
  logic [CW-1:0] ra_q, ra_d;
  logic          cv_q, cv_d;
  logic [AW-1:0] ci_q, ci_d;

  // The containing gap that the scan found.
  logic [AW-1:0] h_q, h_d;
  logic [31:0]   hb_q, hb_d, hl_q, hl_d;

  // Shift sequencer: read pointer, entries left, pending write, direction.
  logic [CW-1:0] sr_q, sr_d, rem_q, rem_d;
  logic          pv_q, pv_d;
  logic [AW-1:0] pw_q, pw_d;
  logic          down_q, down_d;

  logic [2:0]    res_q, res_d;
  logic          out_valid_q, out_valid_d;
  out_t          out_q, out_d;

  // Memory port.
  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [63:0]   wdata, rdata;

  logic [31:0]   rb, rl;
  logic          hit, issue, accept, out_free;
  logic [CW-1:0] h_ext, h_next;

  assign rb       = rdata[63:32];
  assign rl       = rdata[31:0];
  assign hit      = (s_q >= rb) && (e_q <= rl);
  assign issue    = ra_q < cnt_q;
  assign accept   = in_valid_i && in_ready_o;
  assign out_free = !out_valid_q || out_ready_i;
  assign h_ext    = CW'(h_q);
  assign h_next   = h_ext + CW'(1);

  assign in_ready_o  = (st_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  mrgt_ram #(
    .WIDTH (64),
    .DEPTH (MAX_GAPS)
  ) u_gaps (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_comb begin
    st_d        = st_q;
    cnt_d       = cnt_q;
    s_d         = s_q;
    e_d         = e_q;
    fs_d        = fs_q;
    ra_d        = ra_q;
    cv_d        = 1'b0;
    ci_d        = ci_q;
    h_d         = h_q;
    hb_d        = hb_q;
    hl_d        = hl_q;
    sr_d        = sr_q;
    rem_d       = rem_q;
    pv_d        = 1'b0;
    pw_d        = pw_q;
    down_d      = down_q;
    res_d       = res_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    we          = 1'b0;
    waddr       = '0;
    wdata       = '0;
    raddr       = '0;

    case (st_q)
      S_IDLE: begin
        // The last entry is read ahead of time for a final-size item.
        raddr = AW'(cnt_q - CW'(1));
        if (accept) begin
          s_d  = in_data_i.seg_start;
          e_d  = in_data_i.seg_end;
          fs_d = in_data_i.final_size;
          ra_d = '0;
          st_d = S_DONE;
          case (in_data_i.op)
            OP_START: begin
              we    = 1'b1;
              wdata = {32'd0, temp_q};
              cnt_d = (temp_q != 32'd0) ? CW'(1) : '0;
              res_d = OUT_STARTED;
            end
            OP_SEGMENT: begin
              if (in_data_i.seg_start > in_data_i.seg_end) begin
                res_d = OUT_IGNORED;
              end else begin
                st_d = S_SCAN;
              end
            end
            OP_FINAL: begin
              if (cnt_q == '0) begin
                res_d = OUT_NOGAP;
              end else begin
                st_d = S_RSZ;
              end
            end
            default: begin
              res_d = OUT_IGNORED;
            end
          endcase
        end
      end

      S_SCAN: begin
        // One read per cycle; the compare runs in the cycle after the read.
        raddr = ra_q[AW-1:0];
        if (cv_q && hit) begin
          h_d  = ci_q;
          hb_d = rb;
          hl_d = rl;
          st_d = S_ACT;
        end else if (!issue && !cv_q) begin
          res_d = OUT_NOGAP;
          st_d  = S_DONE;
        end else begin
          cv_d = issue;
          ci_d = ra_q[AW-1:0];
          if (issue) begin
            ra_d = ra_q + CW'(1);
          end
        end
      end

      S_ACT: begin
        rem_d = cnt_q - CW'(1) - h_ext;
        if (s_q == hb_q && e_q == hl_q) begin
          sr_d   = h_next;
          down_d = 1'b1;
          st_d   = S_SHF;
        end else if (s_q == hb_q) begin
          we    = 1'b1;
          waddr = h_q;
          wdata = {e_q, hl_q};
          res_d = OUT_TRIMMED;
          st_d  = S_DONE;
        end else if (e_q == hl_q) begin
          we    = 1'b1;
          waddr = h_q;
          wdata = {hb_q, s_q};
          res_d = OUT_TRIMMED;
          st_d  = S_DONE;
        end else if (cnt_q >= CW'(MAX_GAPS)) begin
          res_d = OUT_FULL;
          st_d  = S_DONE;
        end else begin
          sr_d   = cnt_q - CW'(1);
          down_d = 1'b0;
          st_d   = S_SHF;
        end
      end

      S_SHF: begin
        // Read one entry per cycle and write it one place over in the next cycle.
        raddr = sr_q[AW-1:0];
        if (pv_q) begin
          we    = 1'b1;
          waddr = pw_q;
          wdata = rdata;
        end
        if (rem_q != '0) begin
          pv_d  = 1'b1;
          pw_d  = down_q ? AW'(sr_q - CW'(1)) : AW'(sr_q + CW'(1));
          sr_d  = down_q ? sr_q + CW'(1) : sr_q - CW'(1);
          rem_d = rem_q - CW'(1);
        end else if (!pv_q) begin
          if (down_q) begin
            cnt_d = cnt_q - CW'(1);
            res_d = OUT_REMOVED;
            st_d  = S_DONE;
          end else begin
            // Right part of the split gap goes in just after the hole.
            we    = 1'b1;
            waddr = h_next[AW-1:0];
            wdata = {e_q, hl_q};
            st_d  = S_SPL;
          end
        end
      end

      S_SPL: begin
        we    = 1'b1;
        waddr = h_q;
        wdata = {hb_q, s_q};
        cnt_d = cnt_q + CW'(1);
        res_d = OUT_SPLIT;
        st_d  = S_DONE;
      end

      S_RSZ: begin
        // The last gap was read while idle and is on the read port now.
        if (fs_q > rb) begin
          we    = 1'b1;
          waddr = AW'(cnt_q - CW'(1));
          wdata = {rb, fs_q};
        end else begin
          cnt_d = cnt_q - CW'(1);
        end
        res_d = OUT_RESIZED;
        st_d  = S_DONE;
      end

      S_DONE: begin
        if (out_free) begin
          out_valid_d          = 1'b1;
          out_d.outcome        = res_q;
          out_d.gap_total      = 7'(cnt_q);
          out_d.all_received   = (cnt_q == '0);
          st_d                 = S_IDLE;
        end
      end

      default: begin
        st_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= S_IDLE;
      cnt_q       <= '0;
      temp_q      <= TEMP_SIZE_RESET;
      cv_q        <= 1'b0;
      pv_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      st_q        <= st_d;
      cnt_q       <= cnt_d;
      cv_q        <= cv_d;
      pv_q        <= pv_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        temp_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    s_q    <= s_d;
    e_q    <= e_d;
    fs_q   <= fs_d;
    ra_q   <= ra_d;
    ci_q   <= ci_d;
    h_q    <= h_d;
    hb_q   <= hb_d;
    hl_q   <= hl_d;
    sr_q   <= sr_d;
    rem_q  <= rem_d;
    pw_q   <= pw_d;
    down_q <= down_d;
    res_q  <= res_d;
    out_q  <= out_d;
  end

  // The gap count never exceeds the table depth.
  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= CW'(MAX_GAPS))
    else $error("gap count above table depth");

  // A split always adds exactly one gap.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == S_SPL |=> cnt_q == $past(cnt_q) + CW'(1))
    else $error("split did not add one gap");

  // A new result item only appears after the sequencer has finished an item.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(st_q) == S_DONE)
    else $error("result item raised outside the finish step");

  // The memory is written only while an item is in progress.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    we && st_q == S_IDLE |-> accept)
    else $error("gap memory written while idle");

endmodule

`default_nettype wire

// File: design/mrgt_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module mrgt_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire
